// File: rtl/shortest_path_first_hop_table_core_assert.svh
// Assertion macros for the shortest path first hop table core.
`ifndef SHORTEST_PATH_FIRST_HOP_TABLE_CORE_ASSERT_SVH
`define SHORTEST_PATH_FIRST_HOP_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPFH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPFH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spfh_pkg.sv
// Shared constants, codes and controller interface types of the routing table.
`default_nettype none
package spfh_pkg;
   localparam int MAX_NODES  = 256;
   localparam int NODE_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int LEN_W      = 16;
   localparam int DIST_W     = 24;
   localparam int PAIR_W     = 2 * NODE_W;
   localparam int EDGE_W     = LEN_W + 1;
   localparam int NODE_REC_W = 2 + NODE_W + DIST_W;
   localparam int HOP_W      = NODE_W + 1;
   localparam int PAIR_DEPTH = MAX_NODES * MAX_NODES;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_SOLVE = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   localparam logic [1:0] STATUS_ROUTE    = 2'd0;
   localparam logic [1:0] STATUS_SELF     = 2'd1;
   localparam logic [1:0] STATUS_NO_ROUTE = 2'd2;
   localparam logic [1:0] STATUS_DONE     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              clr_ready;
      logic              clr_we;
      logic [PAIR_W-1:0] clr_addr;
      logic              edge_rd_ab;
      logic              edge_wr_ab;
      logic              edge_wr_ba;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] idx;
      logic [NODE_W-1:0] pipe_idx;
      logic              init_we;
      logic              scan_clear;
      logic              scan_rd;
      logic              scan_take;
      logic              settle_we;
      logic              hop_par_rd;
      logic              hop_wr_direct;
      logic              hop_wr_copy;
      logic              relax_rd;
      logic              relax_take;
      logic              qry_rd;
      logic              emit_qry;
      logic              emit_done;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      command_type        item_cmd;
      logic [COUNT_W-1:0] active_n;
      logic               upd_edge;
      logic               found;
      logic               pick_is_src;
      logic               par_is_src;
      logic               slot_free;
   } ctrl_sts_type;
endpackage
`default_nettype wire

// File: rtl/spfh_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
`default_nettype none
module spfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/spfh_ctrl.sv
// Controller state machine that sequences edge loads, solves and queries.
`default_nettype none
module spfh_ctrl
   import spfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_ADD_CHK, S_ADD_WR2, S_INIT, S_SCAN,
      S_SETTLE, S_HOP_CPY, S_RELAX, S_QRY_OUT, S_DONE_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [PAIR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [COUNT_W-1:0] j_ff, j_in;
   logic [NODE_W-1:0]  src_ff, src_in;
   logic               pipe_v_ff, pipe_v_in;
   logic [NODE_W-1:0]  pipe_idx_ff, pipe_idx_in;
   logic [COUNT_W-1:0] n_last;
   logic               issue;

   assign req_tready = (state_ff == S_IDLE);
   assign n_last     = sts.active_n - COUNT_W'(1);
   assign issue      = (j_ff != sts.active_n);

   // Next state, counters and datapath commands.
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      j_in        = j_ff;
      src_in      = src_ff;
      pipe_v_in   = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      cmd          = '0;
      cmd.clr_addr = clr_cnt_ff;
      cmd.src      = src_ff;
      cmd.idx      = j_ff[NODE_W-1:0];
      cmd.pipe_idx = pipe_idx_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_we = 1'b1;
            clr_cnt_in = clr_cnt_ff + PAIR_W'(1);
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.item_cmd)
               CMD_ADD: begin
                  cmd.edge_rd_ab = 1'b1;
                  cmd.clr_ready  = 1'b1;
                  state_in       = S_ADD_CHK;
               end
               CMD_SOLVE: begin
                  src_in = '0;
                  j_in   = '0;
                  if (sts.active_n == '0) begin
                     state_in = S_DONE_OUT;
                  end else begin
                     state_in = S_INIT;
                  end
               end
               CMD_QUERY: begin
                  cmd.qry_rd = 1'b1;
                  state_in   = S_QRY_OUT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ADD_CHK: begin
            if (sts.upd_edge) begin
               cmd.edge_wr_ab = 1'b1;
               state_in       = S_ADD_WR2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD_WR2: begin
            cmd.edge_wr_ba = 1'b1;
            state_in       = S_IDLE;
         end
         S_INIT: begin
            cmd.init_we = 1'b1;
            if (j_ff == n_last) begin
               j_in           = '0;
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else begin
               j_in = j_ff + COUNT_W'(1);
            end
         end
         S_SCAN: begin
            cmd.scan_rd   = issue;
            cmd.scan_take = pipe_v_ff;
            pipe_v_in     = issue;
            pipe_idx_in   = j_ff[NODE_W-1:0];
            if (issue) begin
               j_in = j_ff + COUNT_W'(1);
            end else if (!pipe_v_ff) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            j_in = '0;
            if (!sts.found) begin
               if ({1'b0, src_ff} == n_last) begin
                  state_in = S_DONE_OUT;
               end else begin
                  src_in   = src_ff + NODE_W'(1);
                  state_in = S_INIT;
               end
            end else begin
               cmd.settle_we = 1'b1;
               if (sts.pick_is_src) begin
                  state_in = S_RELAX;
               end else if (sts.par_is_src) begin
                  cmd.hop_wr_direct = 1'b1;
                  state_in          = S_RELAX;
               end else begin
                  cmd.hop_par_rd = 1'b1;
                  state_in       = S_HOP_CPY;
               end
            end
         end
         S_HOP_CPY: begin
            cmd.hop_wr_copy = 1'b1;
            state_in        = S_RELAX;
         end
         S_RELAX: begin
            cmd.relax_rd   = issue;
            cmd.relax_take = pipe_v_ff;
            pipe_v_in      = issue;
            pipe_idx_in    = j_ff[NODE_W-1:0];
            if (issue) begin
               j_in = j_ff + COUNT_W'(1);
            end else if (!pipe_v_ff) begin
               j_in           = '0;
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_QRY_OUT: begin
            if (sts.slot_free) begin
               cmd.emit_qry = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DONE_OUT: begin
            if (sts.slot_free) begin
               cmd.emit_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counter registers; reset starts the edge clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_cnt_ff  <= '0;
         j_ff        <= '0;
         src_ff      <= '0;
         pipe_v_ff   <= 1'b0;
         pipe_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         j_ff        <= j_in;
         src_ff      <= src_in;
         pipe_v_ff   <= pipe_v_in;
         pipe_idx_ff <= pipe_idx_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/spfh_dp.sv
// Datapath: edge, node and hop memories, minimum search, relaxation and result register.
`default_nettype none
module spfh_dp
   import spfh_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        req_tdata,
   input  wire logic [1:0]         req_tuser,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [NODE_W-1:0]       rsp_tdata,
   output logic [1:0]              rsp_tuser,
   input  wire ctrl_cmd_type       cmd,
   output ctrl_sts_type            sts
);
   command_type        cmd_ff;
   logic [NODE_W-1:0]  a_ff, b_ff;
   logic [LEN_W-1:0]   w_ff;
   logic [COUNT_W-1:0] node_count_ff;
   logic               ready_ff;
   logic               found_ff;
   logic [NODE_W-1:0]  pick_ff, pick_par_ff;
   logic [DIST_W-1:0]  pick_dist_ff;
   logic               rsp_valid_ff;
   logic [NODE_W-1:0]  rsp_hop_ff;
   logic [1:0]         rsp_status_ff;

   logic [COUNT_W-1:0] active_n;
   logic                  edge_we, edge_re;
   logic [PAIR_W-1:0]     edge_waddr, edge_raddr;
   logic [EDGE_W-1:0]     edge_wdata, edge_rdata;
   logic                  node_we, node_re;
   logic [NODE_W-1:0]     node_waddr;
   logic [NODE_REC_W-1:0] node_wdata, node_rdata;
   logic                  hop_we, hop_re;
   logic [PAIR_W-1:0]     hop_waddr, hop_raddr;
   logic [HOP_W-1:0]      hop_wdata, hop_rdata;

   logic               e_present;
   logic [LEN_W-1:0]   e_len;
   logic               n_reached, n_settled;
   logic [NODE_W-1:0]  n_par;
   logic [DIST_W-1:0]  n_dist, cand;
   logic               relax_upd, scan_hit;
   logic [NODE_W-1:0]  qry_hop;
   logic [1:0]         qry_status;

   assign active_n = (node_count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                           : node_count_ff;

   // Field views of the memory read data.
   assign e_present = edge_rdata[LEN_W];
   assign e_len     = edge_rdata[LEN_W-1:0];
   assign n_reached = node_rdata[NODE_REC_W-1];
   assign n_settled = node_rdata[NODE_REC_W-2];
   assign n_par     = node_rdata[DIST_W+NODE_W-1:DIST_W];
   assign n_dist    = node_rdata[DIST_W-1:0];
   assign cand      = pick_dist_ff + DIST_W'(e_len);
   assign relax_upd = e_present && !n_settled && (!n_reached || cand < n_dist);
   assign scan_hit  = n_reached && !n_settled && (!found_ff || n_dist < pick_dist_ff);

   // Edge memory ports: clearing pass, edge loads, load checks and relaxation reads.
   assign edge_we    = cmd.clr_we | cmd.edge_wr_ab | cmd.edge_wr_ba;
   assign edge_waddr = cmd.clr_we ? cmd.clr_addr : (cmd.edge_wr_ab ? {a_ff, b_ff} : {b_ff, a_ff});
   assign edge_wdata = cmd.clr_we ? '0 : {1'b1, w_ff};
   assign edge_re    = cmd.edge_rd_ab | cmd.relax_rd;
   assign edge_raddr = cmd.relax_rd ? {pick_ff, cmd.idx} : {a_ff, b_ff};

   // Node record memory ports: per source init, settle, relaxation update, scan and relaxation reads.
   assign node_re = cmd.scan_rd | cmd.relax_rd;
   assign node_we = cmd.init_we | cmd.settle_we | (cmd.relax_take & relax_upd);
   always_comb begin
      if (cmd.init_we) begin
         node_waddr = cmd.idx;
         node_wdata = {(cmd.idx == cmd.src), 1'b0, NODE_W'(0), DIST_W'(0)};
      end else if (cmd.settle_we) begin
         node_waddr = pick_ff;
         node_wdata = {1'b1, 1'b1, pick_par_ff, pick_dist_ff};
      end else begin
         node_waddr = cmd.pipe_idx;
         node_wdata = {1'b1, 1'b0, pick_ff, cand};
      end
   end

   // Hop table ports: row clear, first hop writes, parent and query reads.
   assign hop_we    = cmd.init_we | cmd.hop_wr_direct | cmd.hop_wr_copy;
   assign hop_waddr = cmd.init_we ? {cmd.src, cmd.idx} : {cmd.src, pick_ff};
   assign hop_wdata = cmd.init_we ? '0 : (cmd.hop_wr_direct ? {1'b1, pick_ff} : hop_rdata);
   assign hop_re    = cmd.hop_par_rd | cmd.qry_rd;
   assign hop_raddr = cmd.qry_rd ? {a_ff, b_ff} : {cmd.src, pick_par_ff};

   spfh_ram #(.WIDTH(EDGE_W), .DEPTH(PAIR_DEPTH)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
      .rd_en(edge_re), .rd_addr(edge_raddr), .rd_data(edge_rdata)
   );
   spfh_ram #(.WIDTH(NODE_REC_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_en(node_re), .rd_addr(cmd.idx), .rd_data(node_rdata)
   );
   spfh_ram #(.WIDTH(HOP_W), .DEPTH(PAIR_DEPTH)) u_hop_ram (
      .clock(clock), .wr_en(hop_we), .wr_addr(hop_waddr), .wr_data(hop_wdata),
      .rd_en(hop_re), .rd_addr(hop_raddr), .rd_data(hop_rdata)
   );

   // Query result from range checks and the hop table entry.
   always_comb begin
      qry_hop    = '0;
      qry_status = STATUS_NO_ROUTE;
      if ({1'b0, a_ff} >= active_n || {1'b0, b_ff} >= active_n) begin
         qry_status = STATUS_NO_ROUTE;
      end else if (a_ff == b_ff) begin
         qry_hop    = a_ff;
         qry_status = STATUS_SELF;
      end else if (ready_ff && hop_rdata[NODE_W]) begin
         qry_hop    = hop_rdata[NODE_W-1:0];
         qry_status = STATUS_ROUTE;
      end
   end

   // Item payload, minimum search and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= command_type'(req_tuser);
         a_ff   <= req_tdata[NODE_W-1:0];
         b_ff   <= req_tdata[2*NODE_W-1:NODE_W];
         w_ff   <= req_tdata[2*NODE_W+LEN_W-1:2*NODE_W];
      end
      if (cmd.scan_take && scan_hit) begin
         pick_ff      <= cmd.pipe_idx;
         pick_dist_ff <= n_dist;
         pick_par_ff  <= n_par;
      end
      if (cmd.emit_qry) begin
         rsp_hop_ff    <= qry_hop;
         rsp_status_ff <= qry_status;
      end else if (cmd.emit_done) begin
         rsp_hop_ff    <= '0;
         rsp_status_ff <= STATUS_DONE;
      end
   end

   // Control registers: node count, table ready, search flag, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(1);
         ready_ff      <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         if (csr_we || cmd.clr_ready) begin
            ready_ff <= 1'b0;
         end else if (cmd.emit_done) begin
            ready_ff <= 1'b1;
         end
         if (cmd.scan_clear) begin
            found_ff <= 1'b0;
         end else if (cmd.scan_take && scan_hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.emit_qry || cmd.emit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hop_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign sts.item_cmd    = cmd_ff;
   assign sts.active_n    = active_n;
   assign sts.upd_edge    = !e_present || (w_ff < e_len);
   assign sts.found       = found_ff;
   assign sts.pick_is_src = (pick_ff == cmd.src);
   assign sts.par_is_src  = (pick_par_ff == cmd.src);
   assign sts.slot_free   = !rsp_valid_ff || rsp_tready;
endmodule
`default_nettype wire

// File: rtl/shortest_path_first_hop_table_core.sv
// Top level of the all-pairs shortest path first hop routing table.
//
//   Channel  Direction  Signals                          Contents
//   req      in         req_tvalid/tready/tdata/tuser    edge load, solve or query item
//   rsp      out        rsp_tvalid/tready/tdata/tuser    first hop and status item
//   csr      in         csr_we/csr_wdata                 node count register
//
// After reset the edge memory is cleared, one entry a cycle, with req_tready low.
// A query waits while the output register still holds an unaccepted result.
// A solve over N nodes walks each source: init of its N node records, then per
// settled node the minimum scan and the relaxation pass over the node and edge
// memory read ports, with the first hop copied from its parent's entry where the
// parent is not the source. One item is in work at a time; a result waits in the
// output register while the next item is accepted.
`default_nettype none
`include "shortest_path_first_hop_table_core_assert.svh"
module shortest_path_first_hop_table_core
   import spfh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,  // node_a[7:0], node_b[15:8], weight[31:16]
   input  wire logic [1:0]   req_tuser,  // command[1:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,  // first_hop[7:0]
   output logic [1:0]        rsp_tuser,  // status[1:0]
   input  wire logic         csr_we,
   input  wire logic [8:0]   csr_wdata   // node_count[8:0]
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   spfh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   spfh_dp u_dp (
      .clock(clock), .reset(reset), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .cmd(cmd), .sts(sts)
   );

   // An accepted item keeps the block busy for at least the next cycle.
   `SPFH_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted twice")
   // A result is only loaded while the output register is free.
   `SPFH_ASSERT_NOW(a_emit_slot, cmd.emit_qry || cmd.emit_done, sts.slot_free, "result overrun")
   // A new result appears only after the controller issued one.
   `SPFH_ASSERT_NOW(a_rsp_source, $rose(rsp_tvalid), $past(cmd.emit_qry || cmd.emit_done), "stray result")
endmodule
`default_nettype wire
